FILE: hdl/fla_pkg.sv
package fla_pkg;

   localparam int POOL_DEPTH_DEF = 64;
   localparam int TIME_BITS_DEF  = 32;

   localparam int CNT_W      = 7;
   localparam int OP_W       = 2;
   localparam int SIDX_W     = 6;
   localparam int STAT_W     = 2;
   localparam int CTR_W      = 32;
   localparam int TMO_W      = 32;
   localparam int NOW_W      = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_ACQUIRE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_RECOVER = 2'd2,
      OP_STATUS  = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_RANGE = 2'd2,
      STS_IDLE  = 2'd3
   } status_type;

   typedef struct packed {
      logic rebuild;
      logic pop;
      logic push;
   } stk_ctl_type;

   function automatic int cap_reset(int depth);
      return (depth < 64) ? depth : 64;
   endfunction

   function automatic int cap_max(int depth);
      return (depth < (2 ** CNT_W - 1)) ? depth : (2 ** CNT_W - 1);
   endfunction

endpackage

FILE: hdl/free_list_allocator_with_leak_timeout.sv
// Status and release: result strobe in the cycle after the start transfer.
// Acquire: state S_ACQ covers the registered read of the free stack top; skipped on an empty pool.
// Recover: one slot per cycle through the stamp memory read port
// and the shared age comparator. busy drops in the strobe cycle, which takes the next start.
// rsp_strobe is high for one cycle; the receiver cannot stall.
// Sync active-high reset: min(POOL_DEPTH,64) free slots, counters and timeout zero; no clearing pass.
module free_list_allocator_with_leak_timeout import fla_pkg::*; #(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [SIDX_W-1:0]     req_slot_index,
   input  logic [NOW_W-1:0]      req_now_time,
   output logic                  rsp_strobe,
   output logic [STAT_W-1:0]     rsp_status,
   output logic [SIDX_W-1:0]     rsp_granted_index,
   output logic [CNT_W-1:0]      rsp_reclaim_count,
   output logic [CNT_W-1:0]      rsp_free_slots,
   output logic [CNT_W-1:0]      rsp_busy_slots,
   output logic [CTR_W-1:0]      rsp_total_grants,
   output logic [CTR_W-1:0]      rsp_total_returns,
   output logic [CTR_W-1:0]      rsp_total_recoveries,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int SW    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
   localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(cap_reset(POOL_DEPTH));
   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(cap_max(POOL_DEPTH));

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_ACQ  = 3'b010,
      S_REC  = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cap_ff, cap_in;
   logic [TMO_W-1:0]      timeout_ff, timeout_in;
   logic [POOL_DEPTH-1:0] busy_ff, busy_in;
   logic [CNT_W-1:0]      busy_cnt_ff, busy_cnt_in;
   logic [CTR_W-1:0]      grants_ff, grants_in;
   logic [CTR_W-1:0]      returns_ff, returns_in;
   logic [CTR_W-1:0]      recov_ff, recov_in;
   logic                  strobe_ff, strobe_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   status_type            status_ff, status_in;
   logic [IDX_W-1:0]      granted_ff, granted_in;
   logic [CNT_W-1:0]      rec_cnt_ff, rec_cnt_in;

   stk_ctl_type           stk_ctl;
   logic [IDX_W-1:0]      stk_push_data;
   logic [CNT_W-1:0]      stk_top;
   logic [IDX_W-1:0]      stk_pop_data;
   logic                  stamp_wr_en;
   logic                  expired;
   logic [CNT_W-1:0]      csr_cap;
   logic [IDX_W-1:0]      rel_idx;
   logic                  scan_last;

   fla_stack #(.POOL_DEPTH(POOL_DEPTH)) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stk_ctl),
      .cap       (cap_in),
      .push_data (stk_push_data),
      .top       (stk_top),
      .pop_data  (stk_pop_data)
   );

   fla_stamp #(.POOL_DEPTH(POOL_DEPTH), .TIME_BITS(TIME_BITS)) u_stamp (
      .clock   (clock),
      .wr_en   (stamp_wr_en),
      .wr_addr (stk_pop_data),
      .wr_data (now_ff),
      .rd_addr (addr_in),
      .now     (now_ff),
      .limit   (TIME_BITS'(timeout_ff)),
      .expired (expired)
   );

   always_comb begin
      csr_cap = csr_data[CNT_W-1:0];
      if (csr_cap == '0) begin
         csr_cap = CNT_W'(1);
      end else if (csr_cap > CAP_MAX) begin
         csr_cap = CAP_MAX;
      end
   end

   assign rel_idx   = IDX_W'(req_slot_index);
   assign scan_last = (SW'(addr_ff) + SW'(1)) >= SW'(cap_ff);

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      timeout_in    = timeout_ff;
      busy_in       = busy_ff;
      busy_cnt_in   = busy_cnt_ff;
      grants_in     = grants_ff;
      returns_in    = returns_ff;
      recov_in      = recov_ff;
      strobe_in     = 1'b0;
      now_in        = now_ff;
      addr_in       = addr_ff;
      status_in     = status_ff;
      granted_in    = granted_ff;
      rec_cnt_in    = rec_cnt_ff;
      stk_ctl       = '0;
      stk_push_data = addr_ff;
      stamp_wr_en   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               now_in     = TIME_BITS'(req_now_time);
               granted_in = '0;
               rec_cnt_in = '0;
               status_in  = STS_OK;
               case (op_type'(req_opcode))
                  OP_ACQUIRE: begin
                     if (stk_top == '0) begin
                        status_in = STS_EMPTY;
                        strobe_in = 1'b1;
                     end else begin
                        state_in = S_ACQ;
                     end
                  end
                  OP_RELEASE: begin
                     strobe_in = 1'b1;
                     if ({1'b0, req_slot_index} >= cap_ff) begin
                        status_in = STS_RANGE;
                     end else if (!busy_ff[rel_idx]) begin
                        status_in = STS_IDLE;
                     end else begin
                        stk_ctl.push     = 1'b1;
                        stk_push_data    = rel_idx;
                        busy_in[rel_idx] = 1'b0;
                        busy_cnt_in      = busy_cnt_ff - CNT_W'(1);
                        returns_in       = returns_ff + CTR_W'(1);
                     end
                  end
                  OP_RECOVER: begin
                     addr_in  = '0;
                     state_in = S_REC;
                  end
                  OP_STATUS: begin
                     strobe_in = 1'b1;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_ACQ: begin
            stk_ctl.pop           = 1'b1;
            stamp_wr_en           = 1'b1;
            busy_in[stk_pop_data] = 1'b1;
            busy_cnt_in           = busy_cnt_ff + CNT_W'(1);
            grants_in             = grants_ff + CTR_W'(1);
            granted_in            = stk_pop_data;
            strobe_in             = 1'b1;
            state_in              = S_IDLE;
         end
         S_REC: begin
            if (busy_ff[addr_ff] && expired) begin
               stk_ctl.push     = 1'b1;
               stk_push_data    = addr_ff;
               busy_in[addr_ff] = 1'b0;
               busy_cnt_in      = busy_cnt_ff - CNT_W'(1);
               recov_in         = recov_ff + CTR_W'(1);
               rec_cnt_in       = rec_cnt_ff + CNT_W'(1);
            end
            if (scan_last) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // capacity write rebuilds the pool and wins over any pool update
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SLOTS: begin
               cap_in          = csr_cap;
               stk_ctl.rebuild = 1'b1;
               busy_in         = '0;
               busy_cnt_in     = '0;
               grants_in       = '0;
               returns_in      = '0;
               recov_in        = '0;
            end
            CSR_TIMEOUT: begin
               timeout_in = csr_data[TMO_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cap_ff      <= CAP_RST;
         timeout_ff  <= '0;
         busy_ff     <= '0;
         busy_cnt_ff <= '0;
         grants_ff   <= '0;
         returns_ff  <= '0;
         recov_ff    <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cap_ff      <= cap_in;
         timeout_ff  <= timeout_in;
         busy_ff     <= busy_in;
         busy_cnt_ff <= busy_cnt_in;
         grants_ff   <= grants_in;
         returns_ff  <= returns_in;
         recov_ff    <= recov_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      addr_ff    <= addr_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      rec_cnt_ff <= rec_cnt_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = status_ff;
   assign rsp_granted_index    = SIDX_W'(granted_ff);
   assign rsp_reclaim_count    = rec_cnt_ff;
   assign rsp_free_slots       = stk_top;
   assign rsp_busy_slots       = busy_cnt_ff;
   assign rsp_total_grants     = grants_ff;
   assign rsp_total_returns    = returns_ff;
   assign rsp_total_recoveries = recov_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == S_IDLE))
      else $error("result strobe while a command is in progress");

   a_acq_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACQ) |=> strobe_ff)
      else $error("acquire did not finish after its stack read");

   a_slot_balance: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, stk_top} + {1'b0, busy_cnt_ff}) == {1'b0, cap_ff})
      else $error("free plus busy slots differ from capacity");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == int'(busy_cnt_ff))
      else $error("busy count disagrees with busy slot flags");

endmodule

FILE: hdl/fla_stack.sv
module fla_stack import fla_pkg::*; #(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF,
   localparam int IDX_W = $clog2(POOL_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  stk_ctl_type       ctl,
   input  logic [CNT_W-1:0]  cap,
   input  logic [IDX_W-1:0]  push_data,
   output logic [CNT_W-1:0]  top,
   output logic [IDX_W-1:0]  pop_data
);

   localparam logic [CNT_W-1:0] CAP_RST = CNT_W'(cap_reset(POOL_DEPTH));

   logic [IDX_W-1:0] mem [POOL_DEPTH];
   logic [CNT_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0] low_ff, low_in;
   logic [CNT_W-1:0] rd_ptr;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic             orig_ff;

   // entries below the low mark were never rewritten since rebuild and are read as their own index
   assign rd_ptr  = top_ff - CNT_W'(1);
   assign rd_addr = IDX_W'(rd_ptr);

   always_comb begin
      top_in = top_ff;
      low_in = low_ff;
      if (ctl.rebuild) begin
         top_in = cap;
         low_in = cap;
      end else if (ctl.pop) begin
         top_in = rd_ptr;
         if (rd_ptr < low_ff) begin
            low_in = rd_ptr;
         end
      end else if (ctl.push) begin
         top_in = top_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= CAP_RST;
         low_ff <= CAP_RST;
      end else begin
         top_ff <= top_in;
         low_ff <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.rebuild) begin
         mem[IDX_W'(top_ff)] <= push_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
      orig_ff    <= (rd_ptr < low_ff);
   end

   assign top      = top_ff;
   assign pop_data = orig_ff ? rd_addr_ff : rd_data_ff;

   a_low_mark: assert property (@(posedge clock) disable iff (reset)
      low_ff <= top_ff)
      else $error("free stack low mark above top");

endmodule

FILE: hdl/fla_stamp.sv
module fla_stamp import fla_pkg::*; #(
   parameter int POOL_DEPTH = POOL_DEPTH_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF,
   localparam int IDX_W = $clog2(POOL_DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [TIME_BITS-1:0] wr_data,
   input  logic [IDX_W-1:0]     rd_addr,
   input  logic [TIME_BITS-1:0] now,
   input  logic [TIME_BITS-1:0] limit,
   output logic                 expired
);

   logic [TIME_BITS-1:0] mem [POOL_DEPTH];
   logic [TIME_BITS-1:0] rd_data_ff;
   logic [TIME_BITS-1:0] age;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // age wraps modulo 2^TIME_BITS
   assign age     = now - rd_data_ff;
   assign expired = (age > limit);

endmodule

FILE: verif/tb_free_list_allocator_with_leak_timeout.sv
`timescale 1ns / 100ps

module tb_free_list_allocator_with_leak_timeout;
   import fla_pkg::*;

   localparam int DEPTH              = POOL_DEPTH_DEF;
   localparam int PHASE_ITEMS        = 150;
   localparam int STALL_LIMIT        = 3000;
   localparam int SETTLE_CYCLES      = 80;

   typedef struct packed {
      status_type             status;
      logic [SIDX_W-1:0]      granted;
      logic [CNT_W-1:0]       recovered;
      logic [CNT_W-1:0]       free_cnt;
      logic [CNT_W-1:0]       busy_cnt;
      logic [CTR_W-1:0]       grants;
      logic [CTR_W-1:0]       returns;
      logic [CTR_W-1:0]       recoveries;
   } alloc_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [OP_W-1:0]       req_opcode;
   logic [SIDX_W-1:0]     req_slot_index;
   logic [NOW_W-1:0]      req_now_time;
   logic                  rsp_strobe;
   logic [STAT_W-1:0]     rsp_status;
   logic [SIDX_W-1:0]     rsp_granted_index;
   logic [CNT_W-1:0]      rsp_reclaim_count;
   logic [CNT_W-1:0]      rsp_free_slots;
   logic [CNT_W-1:0]      rsp_busy_slots;
   logic [CTR_W-1:0]      rsp_total_grants;
   logic [CTR_W-1:0]      rsp_total_returns;
   logic [CTR_W-1:0]      rsp_total_recoveries;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // pool shadow state
   int                    pool_cap;
   logic [TMO_W-1:0]      leak_limit;
   logic [SIDX_W-1:0]     pool_stack [0:DEPTH-1];
   logic [CNT_W-1:0]      pool_top;
   logic [CNT_W-1:0]      held_total;
   bit                    slot_held  [0:DEPTH-1];
   logic [NOW_W-1:0]      slot_stamp [0:DEPTH-1];
   logic [CTR_W-1:0]      grant_ctr;
   logic [CTR_W-1:0]      return_ctr;
   logic [CTR_W-1:0]      recovery_ctr;

   alloc_outcome_type     alloc_outcome_q [$];
   alloc_outcome_type     owed;
   int                    mismatch_count = 0;
   bit                    idle_enabled = 1'b1;
   int                    stall_cycles = 0;

   free_list_allocator_with_leak_timeout i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_slot_index       (req_slot_index),
      .req_now_time         (req_now_time),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_granted_index    (rsp_granted_index),
      .rsp_reclaim_count    (rsp_reclaim_count),
      .rsp_free_slots       (rsp_free_slots),
      .rsp_busy_slots       (rsp_busy_slots),
      .rsp_total_grants     (rsp_total_grants),
      .rsp_total_returns    (rsp_total_returns),
      .rsp_total_recoveries (rsp_total_recoveries),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatch_count < 100) begin
         $display("%0t ns: %s got %0h want %0h", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   function automatic void rebuild_pool();
      for (int k = 0; k < DEPTH; k++) begin
         pool_stack[k] = SIDX_W'(k);
         slot_held[k]  = 1'b0;
         slot_stamp[k] = '0;
      end
      pool_top     = CNT_W'(pool_cap);
      held_total   = '0;
      grant_ctr    = '0;
      return_ctr   = '0;
      recovery_ctr = '0;
   endfunction

   function automatic void return_slot(input logic [SIDX_W-1:0] idx);
      if (pool_top < DEPTH) begin
         pool_stack[pool_top[SIDX_W-1:0]] = idx;
         pool_top++;
      end
      slot_held[idx] = 1'b0;
      if (held_total > 0) held_total--;
   endfunction

   function automatic void compute_alloc_outcome(input op_type op,
                                                 input logic [SIDX_W-1:0] idx,
                                                 input logic [NOW_W-1:0] now);
      alloc_outcome_type o;
      logic [SIDX_W-1:0] g;
      logic [NOW_W-1:0]  age;
      o = '0;
      o.status = STS_OK;
      case (op)
         OP_ACQUIRE: begin
            if (pool_top == 0) begin
               o.status = STS_EMPTY;
            end else begin
               pool_top--;
               g = pool_stack[pool_top[SIDX_W-1:0]];
               slot_held[g]  = 1'b1;
               slot_stamp[g] = now;
               held_total++;
               grant_ctr++;
               o.granted = g;
            end
         end
         OP_RELEASE: begin
            if (idx >= pool_cap) begin
               o.status = STS_RANGE;
            end else if (!slot_held[idx]) begin
               o.status = STS_IDLE;
            end else begin
               return_slot(idx);
               return_ctr++;
            end
         end
         OP_RECOVER: begin
            for (int i = 0; i < pool_cap; i++) begin
               if (slot_held[i]) begin
                  age = now - slot_stamp[i];
                  if (age > leak_limit) begin
                     return_slot(SIDX_W'(i));
                     recovery_ctr++;
                     o.recovered++;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      o.free_cnt   = pool_top;
      o.busy_cnt   = held_total;
      o.grants     = grant_ctr;
      o.returns    = return_ctr;
      o.recoveries = recovery_ctr;
      alloc_outcome_q.push_back(o);
   endfunction

   task automatic send_item(input op_type op, input logic [SIDX_W-1:0] idx,
                            input logic [NOW_W-1:0] now);
      if (idle_enabled && $urandom_range(99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_slot_index <= idx;
      req_now_time   <= now;
      @(posedge clock);
      while (busy) @(posedge clock);
      compute_alloc_outcome(op, idx, now);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      int c;
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_SLOTS) begin
         c = int'(data[CNT_W-1:0]);
         if (c == 0) c = 1;
         if (c > DEPTH) c = DEPTH;
         pool_cap = c;
         rebuild_pool();
      end else begin
         leak_limit = data;
      end
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      while (alloc_outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic test_after_reset();
      send_item(OP_ACQUIRE, '0, '0);
      send_item(OP_ACQUIRE, 6'h2A, 32'hFFFF_FFFF);
      send_item(OP_RELEASE, 6'h3F, '0);
      send_item(OP_RELEASE, 6'h3F, '0);
      send_item(OP_RECOVER, '0, '0);
   endtask

   task automatic test_capacity_limits();
      drain_pipeline();
      write_csr(CSR_SLOTS, 32'd0);
      send_item(OP_STATUS, 6'h15, 32'h5555_5555);
      send_item(OP_ACQUIRE, '0, 32'd7);
      send_item(OP_ACQUIRE, '0, 32'd8);
      send_item(OP_RELEASE, 6'd1, '0);
      send_item(OP_RELEASE, 6'h3F, '0);
      send_item(OP_RELEASE, 6'd0, '0);
      send_item(OP_RELEASE, 6'd0, '0);
      drain_pipeline();
      // upper data bits are not part of the capacity
      write_csr(CSR_SLOTS, 32'hFFFF_FF85);
      send_item(OP_ACQUIRE, '0, 32'hAAAA_AAAA);
      drain_pipeline();
      write_csr(CSR_SLOTS, 32'd127);
      send_item(OP_ACQUIRE, '0, '0);
      drain_pipeline();
      write_csr(CSR_SLOTS, DEPTH);
   endtask

   task automatic test_leak_timeout();
      drain_pipeline();
      write_csr(CSR_SLOTS, 32'd8);
      write_csr(CSR_TIMEOUT, 32'd0);
      repeat (3) send_item(OP_ACQUIRE, '0, 32'd100);
      send_item(OP_RECOVER, '0, 32'd100);
      send_item(OP_RECOVER, '0, 32'd101);
      drain_pipeline();
      write_csr(CSR_TIMEOUT, 32'hFFFF_FFFF);
      send_item(OP_ACQUIRE, '0, '0);
      send_item(OP_RECOVER, '0, 32'hFFFF_FFFF);
      drain_pipeline();
      // timeout write leaves held slots and counters alone
      write_csr(CSR_TIMEOUT, 32'hFFFF_FFFE);
      send_item(OP_RECOVER, '0, 32'hFFFF_FFFF);
      drain_pipeline();
      write_csr(CSR_TIMEOUT, 32'd10);
      send_item(OP_ACQUIRE, '0, 32'hFFFF_FFFA);
      send_item(OP_RECOVER, '0, 32'd4);
      send_item(OP_RECOVER, '0, 32'd5);
      send_item(OP_RELEASE, 6'd7, '0);
   endtask

   task automatic run_random_phase(input int cap, input logic [TMO_W-1:0] tmo,
                                   input logic [NOW_W-1:0] t0, input int acq_pct,
                                   input bit idle_en);
      logic [CSR_DATA_W-1:0] cap_word;
      logic [NOW_W-1:0]      clk_s;
      logic [NOW_W-1:0]      now;
      logic [SIDX_W-1:0]     idx;
      op_type                op;
      int                    r;
      int                    held_q [$];
      drain_pipeline();
      cap_word = $urandom;
      cap_word[CNT_W-1:0] = CNT_W'(cap);
      write_csr(CSR_SLOTS, cap_word);
      write_csr(CSR_TIMEOUT, tmo);
      idle_enabled = idle_en;
      clk_s = t0;
      repeat (PHASE_ITEMS) begin
         clk_s += $urandom_range(0, 12);
         now = ($urandom_range(99) < 4) ? $urandom : clk_s;
         held_q.delete();
         for (int i = 0; i < pool_cap; i++) begin
            if (slot_held[i]) held_q.push_back(i);
         end
         if (held_q.size() > 0 && $urandom_range(9) < 8) begin
            idx = SIDX_W'(held_q[$urandom_range(held_q.size() - 1)]);
         end else begin
            idx = SIDX_W'($urandom_range(DEPTH - 1));
         end
         r = $urandom_range(99);
         if (r < acq_pct) op = OP_ACQUIRE;
         else if (r < acq_pct + 30) op = OP_RELEASE;
         else if (r < acq_pct + 42) op = OP_RECOVER;
         else op = OP_STATUS;
         send_item(op, idx, now);
      end
      idle_enabled = 1'b1;
   endtask

   task automatic test_random_traffic();
      run_random_phase(64, 32'd40, $urandom, 45, 1'b1);
      run_random_phase(1, 32'd0, $urandom, 40, 1'b1);
      run_random_phase(64, 32'd200, 32'hFFFF_FD00, 50, 1'b0);
      run_random_phase(3, 32'd5, $urandom, 40, 1'b1);
      run_random_phase(17, 32'hFFFF_FFFF, $urandom, 40, 1'b1);
      run_random_phase(100, 32'd20, $urandom, 50, 1'b1);
      run_random_phase(33, $urandom_range(0, 60), $urandom, 45, 1'b1);
      run_random_phase(8, 32'd0, $urandom, 40, 1'b1);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (alloc_outcome_q.size() == 0) begin
            flag_mismatch("rsp transfer with nothing owed", 32'd1, 32'd0);
         end else begin
            owed = alloc_outcome_q.pop_front();
            if (rsp_status !== owed.status)
               flag_mismatch("status", 32'(rsp_status), 32'(owed.status));
            if (rsp_granted_index !== owed.granted)
               flag_mismatch("granted_index", 32'(rsp_granted_index), 32'(owed.granted));
            if (rsp_reclaim_count !== owed.recovered)
               flag_mismatch("reclaim_count", 32'(rsp_reclaim_count), 32'(owed.recovered));
            if (rsp_free_slots !== owed.free_cnt)
               flag_mismatch("free_slots", 32'(rsp_free_slots), 32'(owed.free_cnt));
            if (rsp_busy_slots !== owed.busy_cnt)
               flag_mismatch("busy_slots", 32'(rsp_busy_slots), 32'(owed.busy_cnt));
            if (rsp_total_grants !== owed.grants)
               flag_mismatch("total_grants", rsp_total_grants, owed.grants);
            if (rsp_total_returns !== owed.returns)
               flag_mismatch("total_returns", rsp_total_returns, owed.returns);
            if (rsp_total_recoveries !== owed.recoveries)
               flag_mismatch("total_recoveries", rsp_total_recoveries, owed.recoveries);
         end
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_STATUS;
      req_slot_index = '0;
      req_now_time   = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_SLOTS;
      csr_data       = '0;
      pool_cap       = DEPTH;
      leak_limit     = '0;
      rebuild_pool();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_capacity_limits();
      test_leak_timeout();
      test_random_traffic();
      drain_pipeline();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
